/* sv/lsf_pkg.sv */
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types and constants of the least-squares line fit: the item and
// result beats, the controller command and status groups, and the widths.
// ----------------------------------------------------------------------------
package lsf_pkg;

	// Width of the point counter.
	localparam int COUNT_BITS = 16;
	localparam int MIN_POINTS = 2;

	// Running sums.
	localparam int SUM_W  = 32;
	localparam int SUM2_W = 48;

	// Multiplier operands: A is a sign-extended 48-bit sum, B a 33-bit value.
	localparam int OPA_W   = 48;
	localparam int OPB_W   = 33;
	localparam int CHUNK_W = 32;
	localparam int PP_W    = 2 * CHUNK_W;

	// Signed accumulator that holds the determinant and both numerators.
	localparam int ACC_W = 82;
	localparam int NUM_W = ACC_W + 16;

	// Quotient bits produced by the divider; anything wider saturates.
	localparam int QBITS = 33;
	localparam int RES_W = 32;

	// Three terms, two products each, two chunks per product.
	localparam int MUL_STEPS = 12;
	localparam int STEP_W    = $clog2(MUL_STEPS);
	localparam int CTR_W     = $clog2(QBITS);

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_NONE   = 2'd3
	} lsf_kind_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] x_value;
		logic signed [15:0] y_value;
	} lsf_item_t;

	typedef struct packed {
		logic signed [31:0] intercept;
		logic signed [31:0] slope;
		logic               fit_invalid;
		logic [15:0]        point_count;
		logic               underflow;
	} lsf_result_t;

	typedef struct packed {
		logic              capture;
		logic              update;
		logic              mul;
		logic [STEP_W-1:0] step;
		logic              div_load;
		logic              div_step;
		logic              div_end;
		logic              div_sel;
		logic              load_out;
	} lsf_cmd_t;

	typedef struct packed {
		logic fit_ok;
		logic out_free;
	} lsf_status_t;

endpackage

/* sv/least_squares_line_fit_top.sv */
// Items are taken one at a time: a new item is accepted only after the last has
// passed the sum update, 12 steps of the 32x32 multiplier, two 33-step passes
// of the shared restoring divider (skipped when the fit is invalid: fewer than
// two points or zero det) and the hand-off to the result register.
// Reset (arst_n low) clears the count and all sums and empties the result reg.
// ----------------------------------------------------------------------------
// least_squares_line_fit_top
// Running least-squares line fit over added and removed Q8.8 points, giving
// intercept and slope in Q16.16 after every item.
// ----------------------------------------------------------------------------
module least_squares_line_fit_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  lsf_pkg::lsf_item_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output lsf_pkg::lsf_result_t result
);
	import lsf_pkg::*;

	lsf_cmd_t    cmd;
	lsf_status_t status;

	lsf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	lsf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

/* sv/lsf_ctrl.sv */
// ----------------------------------------------------------------------------
// lsf_ctrl
// Sequencer of the line fit: sum update, twelve multiply steps, two
// bit-serial divisions (only when the fit is valid) and the hand-off to the result register.
// ----------------------------------------------------------------------------
module lsf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  lsf_pkg::lsf_status_t status,
	output lsf_pkg::lsf_cmd_t    cmd
);
	import lsf_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_UPDATE = 7'b0000010,
		S_MUL    = 7'b0000100,
		S_DLOAD  = 7'b0001000,
		S_DSTEP  = 7'b0010000,
		S_DEND   = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	state_t           state_q, state_d;
	logic [CTR_W-1:0] ctr_q, ctr_d;
	logic             sel_q, sel_d;

	always_comb begin
		state_d    = state_q;
		ctr_d      = ctr_q;
		sel_d      = sel_q;
		item_ready = 1'b0;
		cmd        = '0;
		cmd.step    = ctr_q[STEP_W-1:0];
		cmd.div_sel = sel_q;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				ctr_d      = '0;
				state_d    = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				if (ctr_q == CTR_W'(MUL_STEPS - 1)) begin
					ctr_d   = '0;
					sel_d   = 1'b0;
					// Without a usable determinant there is nothing to divide.
					state_d = status.fit_ok ? S_DLOAD : S_FINISH;
				end else begin
					ctr_d = ctr_q + 1'b1;
				end
			end
			S_DLOAD: begin
				cmd.div_load = 1'b1;
				ctr_d        = '0;
				state_d      = S_DSTEP;
			end
			S_DSTEP: begin
				cmd.div_step = 1'b1;
				if (ctr_q == CTR_W'(QBITS - 1)) begin
					state_d = S_DEND;
				end else begin
					ctr_d = ctr_q + 1'b1;
				end
			end
			S_DEND: begin
				cmd.div_end = 1'b1;
				if (sel_q) begin
					state_d = S_FINISH;
				end else begin
					sel_d   = 1'b1;
					state_d = S_DLOAD;
				end
			end
			S_FINISH: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ctr_q   <= '0;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ctr_q   <= ctr_d;
			sel_q   <= sel_d;
		end
	end

endmodule

/* sv/lsf_dp.sv */
// ----------------------------------------------------------------------------
// lsf_dp
// Datapath of the line fit: running sums, a shared 32x32 multiplier feeding
// a signed accumulator, a restoring divider and the result register.
// ----------------------------------------------------------------------------
module lsf_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lsf_pkg::lsf_item_t   item,
	input  lsf_pkg::lsf_cmd_t    cmd,
	output lsf_pkg::lsf_status_t status,
	output logic                 result_valid,
	input  logic                 result_ready,
	output lsf_pkg::lsf_result_t result
);
	import lsf_pkg::*;

	// Captured item.
	lsf_item_t item_q;

	// Running sums, two's complement.
	logic [COUNT_BITS-1:0] cnt_q;
	logic [SUM_W-1:0]      sx_q, sy_q;
	logic [SUM2_W-1:0]     sxx_q, sxy_q;
	logic                  under_q;

	// Products of the captured point.
	logic signed [31:0] xx, xy;
	logic               cnt_full, cnt_zero;

	// Multiply stage.
	logic [1:0]         term;
	logic               prod, chunk;
	logic [OPA_W-1:0]   a_op, a_mag;
	logic [OPB_W-1:0]   b_op, b_mag33;
	logic [CHUNK_W-1:0] a_chunk, b_mag;
	logic [PP_W-1:0]    pp;
	logic [PP_W+CHUNK_W-1:0] pp_wide;
	logic [ACC_W-1:0]   pp_ext, acc_base, acc_next;
	logic               pp_neg;
	logic [ACC_W-1:0]   acc_q, det_q, num0_q, num1_q;

	// Divider.
	logic [ACC_W-1:0] den, num_sel, num_abs, rem_q;
	logic [NUM_W-1:0] num_mag;
	logic [ACC_W:0]   trial;
	logic             trial_ge;
	logic [QBITS-1:0] low_q;
	logic             neg_q, ovf_q;
	logic [RES_W-1:0] quot_sat, int_q, slope_q;

	logic fit_ok;
	logic out_valid_q;

	assign xx       = item_q.x_value * item_q.x_value;
	assign xy       = item_q.x_value * item_q.y_value;
	assign cnt_full = &cnt_q;
	assign cnt_zero = ~|cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sx_q    <= '0;
			sxx_q   <= '0;
			sy_q    <= '0;
			sxy_q   <= '0;
			under_q <= 1'b0;
		end else if (cmd.update) begin
			under_q <= 1'b0;
			unique case (item_q.kind)
				KIND_ADD: begin
					if (!cnt_full) begin
						cnt_q <= cnt_q + 1'b1;
						sx_q  <= sx_q + SUM_W'(item_q.x_value);
						sy_q  <= sy_q + SUM_W'(item_q.y_value);
						sxx_q <= sxx_q + SUM2_W'(xx);
						sxy_q <= sxy_q + SUM2_W'(xy);
					end
				end
				KIND_REMOVE: begin
					if (cnt_zero) begin
						under_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
						sx_q  <= sx_q - SUM_W'(item_q.x_value);
						sy_q  <= sy_q - SUM_W'(item_q.y_value);
						sxx_q <= sxx_q - SUM2_W'(xx);
						sxy_q <= sxy_q - SUM2_W'(xy);
					end
				end
				KIND_CLEAR: begin
					cnt_q <= '0;
					sx_q  <= '0;
					sxx_q <= '0;
					sy_q  <= '0;
					sxy_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Step layout: term (det, num0, num1), product within the term, chunk of A.
	// The second product of every term is subtracted.
	assign term  = cmd.step[3:2];
	assign prod  = cmd.step[1];
	assign chunk = cmd.step[0];

	always_comb begin
		unique case ({term, prod})
			3'b000: begin
				a_op = sxx_q;
				b_op = OPB_W'(cnt_q);
			end
			3'b001: begin
				a_op = OPA_W'(signed'(sx_q));
				b_op = OPB_W'(signed'(sx_q));
			end
			3'b010: begin
				a_op = sxx_q;
				b_op = OPB_W'(signed'(sy_q));
			end
			3'b011: begin
				a_op = sxy_q;
				b_op = OPB_W'(signed'(sx_q));
			end
			3'b100: begin
				a_op = sxy_q;
				b_op = OPB_W'(cnt_q);
			end
			3'b101: begin
				a_op = OPA_W'(signed'(sy_q));
				b_op = OPB_W'(signed'(sx_q));
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	assign a_mag   = a_op[OPA_W-1] ? (~a_op + 1'b1) : a_op;
	assign b_mag33 = b_op[OPB_W-1] ? (~b_op + 1'b1) : b_op;
	assign b_mag   = b_mag33[CHUNK_W-1:0];
	assign a_chunk = chunk ? CHUNK_W'(a_mag[OPA_W-1:CHUNK_W]) : a_mag[CHUNK_W-1:0];
	assign pp      = a_chunk * b_mag;
	assign pp_wide = chunk ? {pp, {CHUNK_W{1'b0}}} : (PP_W + CHUNK_W)'(pp);
	assign pp_ext  = pp_wide[ACC_W-1:0];
	assign pp_neg  = a_op[OPA_W-1] ^ b_op[OPB_W-1] ^ prod;
	assign acc_base = (cmd.step[1:0] == 2'b00) ? '0 : acc_q;
	assign acc_next = acc_base + (pp_neg ? (~pp_ext + 1'b1) : pp_ext);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			acc_q <= acc_next;
			if (cmd.step[1:0] == 2'b11) begin
				unique case (term)
					2'd0:    det_q  <= acc_next;
					2'd1:    num0_q <= acc_next;
					default: num1_q <= acc_next;
				endcase
			end
		end
	end

	assign fit_ok = (cnt_q >= COUNT_BITS'(MIN_POINTS)) && (|det_q);

	// Intercept numerator is scaled by 2^8, slope numerator by 2^16.
	assign den     = det_q[ACC_W-1] ? (~det_q + 1'b1) : det_q;
	assign num_sel = cmd.div_sel ? num1_q : num0_q;
	assign num_abs = num_sel[ACC_W-1] ? (~num_sel + 1'b1) : num_sel;
	assign num_mag = cmd.div_sel ? {num_abs, 16'b0} : {8'b0, num_abs, 8'b0};

	assign trial    = {rem_q, low_q[QBITS-1]};
	assign trial_ge = trial >= (ACC_W + 1)'(den);

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			// A quotient of 2^QBITS or more saturates whatever its sign.
			rem_q <= ACC_W'(num_mag[NUM_W-1:QBITS]);
			low_q <= num_mag[QBITS-1:0];
			ovf_q <= ACC_W'(num_mag[NUM_W-1:QBITS]) >= den;
			neg_q <= num_sel[ACC_W-1] ^ det_q[ACC_W-1];
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? ACC_W'(trial - (ACC_W + 1)'(den)) : trial[ACC_W-1:0];
			low_q <= {low_q[QBITS-2:0], trial_ge};
		end
	end

	always_comb begin
		if (!neg_q) begin
			if (ovf_q || low_q > QBITS'(32'h7FFF_FFFF)) begin
				quot_sat = 32'h7FFF_FFFF;
			end else begin
				quot_sat = low_q[RES_W-1:0];
			end
		end else begin
			if (ovf_q || low_q > QBITS'(32'h8000_0000)) begin
				quot_sat = 32'h8000_0000;
			end else begin
				quot_sat = ~low_q[RES_W-1:0] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_end) begin
			if (cmd.div_sel) begin
				slope_q <= quot_sat;
			end else begin
				int_q <= quot_sat;
			end
		end
	end

	// Result register; a finished beat may wait here while the next item runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result.intercept   <= fit_ok ? int_q : '0;
			result.slope       <= fit_ok ? slope_q : '0;
			result.fit_invalid <= ~fit_ok;
			result.point_count <= 16'(cnt_q);
			result.underflow   <= under_q;
		end
	end

	assign result_valid    = out_valid_q;
	assign status.fit_ok   = fit_ok;
	assign status.out_free = ~out_valid_q | result_ready;

endmodule
